// ----- rtl/gps_duty_cycle_power_manager_core_assert.svh -----
// Assertion macros for the duty-cycle power manager checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef GPS_DUTY_CYCLE_POWER_MANAGER_CORE_ASSERT_SVH
`define GPS_DUTY_CYCLE_POWER_MANAGER_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define GDCPM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("power manager check failed");

// Next-cycle implication, ignored while reset is asserted.
`define GDCPM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("power manager check failed");

`endif

// ----- rtl/gdcpm_pkg.sv -----
// Shared codes and constants for the duty-cycle power manager.
// No dependencies; used by the core and its checker.
package gdcpm_pkg;

    // Operating modes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_INTER = 2'd2;
    // Requested mode with no meaning; the block keeps its mode
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    // Intermittent phases
    localparam logic [1:0] PH_AWAIT  = 2'd0;
    localparam logic [1:0] PH_SLEEP  = 2'd1;
    localparam logic [1:0] PH_RESYNC = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SLEEP_PERIOD  = 2'd0;
    localparam logic [1:0] CFG_RESYNC_WINDOW = 2'd1;

    // Register reset values
    localparam logic [31:0] SLEEP_PERIOD_RST  = 32'd3600000;
    localparam logic [31:0] RESYNC_WINDOW_RST = 32'd300000;

    // Supply current estimates in mA
    localparam logic [4:0] ACTIVE_MA = 5'd20;
    localparam logic [4:0] IDLE_MA   = 5'd0;

endpackage

// ----- rtl/gps_duty_cycle_power_manager_core.sv -----
// Duty-cycle power manager core, built on gdcpm_pkg: one result per tick. Each tick is
// registered in the input register, and its result then in the result register.
// Throughput: one tick per cycle; the state update is a single 32-bit add and
// compare per deadline between the input and result registers; only m_ready stalls.
// Reset (synchronous, active low) sets mode off, phase awaiting first sync,
// stamps and deadlines to zero, and both timing registers to their defaults.
module gps_duty_cycle_power_manager_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // tick input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_now_ms,
    input  logic [31:0] s_sync_stamp_ms,
    input  logic [1:0]  s_requested_mode,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_receiver_awake,
    output logic [1:0]  m_active_mode,
    output logic [1:0]  m_duty_phase,
    output logic        m_reverted_off,
    output logic [4:0]  m_current_estimate_ma
);

    // configuration registers
    logic [31:0] sleep_period_reg;
    logic [31:0] resync_window_reg;

    // block state
    logic [1:0]  mode_reg,        mode_next;
    logic [1:0]  phase_reg,       phase_next;
    logic [31:0] last_sync_reg,   last_sync_next;
    logic [31:0] sleep_dl_reg,    sleep_dl_next;
    logic [31:0] resync_dl_reg,   resync_dl_next;
    logic        awake_reg,       awake_next;

    // input register
    logic        in_valid_reg;
    logic [31:0] now_reg;
    logic [31:0] stamp_reg;
    logic [1:0]  req_reg;

    // result register
    logic        out_valid_reg;
    logic        out_awake_reg,   out_awake_next;
    logic [1:0]  out_mode_reg;
    logic [1:0]  out_phase_reg,   out_phase_next;
    logic        out_revert_reg,  out_revert_next;
    logic [4:0]  out_ma_reg,      out_ma_next;

    logic out_free;
    logic advance;
    logic new_sync;
    logic mode_change;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;

    // Take configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sleep_period_reg  <= gdcpm_pkg::SLEEP_PERIOD_RST;
            resync_window_reg <= gdcpm_pkg::RESYNC_WINDOW_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                gdcpm_pkg::CFG_SLEEP_PERIOD:  sleep_period_reg  <= cfg_data;
                gdcpm_pkg::CFG_RESYNC_WINDOW: resync_window_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the tick in the input register until the result side frees up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg   <= s_now_ms;
            stamp_reg <= s_sync_stamp_ms;
            req_reg   <= s_requested_mode;
        end
    end

    // Apply a mode change, then run one step of the intermittent cycle
    always_comb begin
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        last_sync_next  = last_sync_reg;
        sleep_dl_next   = sleep_dl_reg;
        resync_dl_next  = resync_dl_reg;
        awake_next      = awake_reg;
        out_revert_next = 1'b0;

        mode_change = (req_reg != gdcpm_pkg::MODE_RSVD) && (req_reg != mode_reg);
        if (mode_change) begin
            mode_next = req_reg;
            unique case (req_reg)
                gdcpm_pkg::MODE_OFF: awake_next = 1'b0;
                gdcpm_pkg::MODE_ON:  awake_next = 1'b1;
                default: begin
                    awake_next     = 1'b1;
                    phase_next     = gdcpm_pkg::PH_AWAIT;
                    last_sync_next = stamp_reg;
                    sleep_dl_next  = '0;
                    resync_dl_next = '0;
                end
            endcase
        end

        new_sync = (stamp_reg != '0) && (stamp_reg != last_sync_next);

        if (mode_next == gdcpm_pkg::MODE_INTER) begin
            unique case (phase_next)
                gdcpm_pkg::PH_AWAIT: begin
                    if (new_sync) begin
                        last_sync_next = stamp_reg;
                        awake_next     = 1'b0;
                        sleep_dl_next  = now_reg + sleep_period_reg;
                        phase_next     = gdcpm_pkg::PH_SLEEP;
                    end
                end
                gdcpm_pkg::PH_SLEEP: begin
                    if (now_reg >= sleep_dl_next) begin
                        awake_next     = 1'b1;
                        resync_dl_next = now_reg + resync_window_reg;
                        phase_next     = gdcpm_pkg::PH_RESYNC;
                    end
                end
                gdcpm_pkg::PH_RESYNC: begin
                    if (new_sync) begin
                        last_sync_next = stamp_reg;
                        awake_next     = 1'b0;
                        sleep_dl_next  = now_reg + sleep_period_reg;
                        phase_next     = gdcpm_pkg::PH_SLEEP;
                    end else if (now_reg >= resync_dl_next) begin
                        awake_next      = 1'b0;
                        mode_next       = gdcpm_pkg::MODE_OFF;
                        out_revert_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        out_awake_next = awake_next;
        out_phase_next = (mode_next == gdcpm_pkg::MODE_INTER) ?
                         phase_next : gdcpm_pkg::PH_AWAIT;
        case (mode_next)
            gdcpm_pkg::MODE_OFF: out_ma_next = gdcpm_pkg::IDLE_MA;
            gdcpm_pkg::MODE_ON:  out_ma_next = gdcpm_pkg::ACTIVE_MA;
            default: out_ma_next = (phase_next == gdcpm_pkg::PH_SLEEP) ?
                                   gdcpm_pkg::IDLE_MA : gdcpm_pkg::ACTIVE_MA;
        endcase
    end

    // Advance the state once per transferred tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= gdcpm_pkg::MODE_OFF;
            phase_reg     <= gdcpm_pkg::PH_AWAIT;
            last_sync_reg <= '0;
            sleep_dl_reg  <= '0;
            resync_dl_reg <= '0;
            awake_reg     <= 1'b0;
        end else if (advance) begin
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            last_sync_reg <= last_sync_next;
            sleep_dl_reg  <= sleep_dl_next;
            resync_dl_reg <= resync_dl_next;
            awake_reg     <= awake_next;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_awake_reg  <= out_awake_next;
            out_mode_reg   <= mode_next;
            out_phase_reg  <= out_phase_next;
            out_revert_reg <= out_revert_next;
            out_ma_reg     <= out_ma_next;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_receiver_awake      = out_awake_reg;
    assign m_active_mode         = out_mode_reg;
    assign m_duty_phase          = out_phase_reg;
    assign m_reverted_off        = out_revert_reg;
    assign m_current_estimate_ma = out_ma_reg;

endmodule

// ----- rtl/gdcpm_checker.sv -----
// Port-level checker for the duty-cycle power manager, bound to the core.
// Depends on gdcpm_pkg and gps_duty_cycle_power_manager_core_assert.svh.
`include "gps_duty_cycle_power_manager_core_assert.svh"

module gdcpm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_receiver_awake,
    input logic [1:0]  m_active_mode,
    input logic [1:0]  m_duty_phase,
    input logic        m_reverted_off,
    input logic [4:0]  m_current_estimate_ma
);

    // A stalled result transfer keeps its payload
    `GDCPM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_active_mode) && $stable(m_receiver_awake)
        && $stable(m_current_estimate_ma))

    // A revert leaves the receiver in standby with mode off and no phase
    `GDCPM_ASSERT_NOW(a_revert_off, aclk, aresetn, m_valid && m_reverted_off,
        m_active_mode == gdcpm_pkg::MODE_OFF && !m_receiver_awake
        && m_duty_phase == gdcpm_pkg::PH_AWAIT)

    // Outside intermittent mode the phase reads as zero
    `GDCPM_ASSERT_NOW(a_phase_zero, aclk, aresetn,
        m_valid && m_active_mode != gdcpm_pkg::MODE_INTER,
        m_duty_phase == gdcpm_pkg::PH_AWAIT)

    // In on mode the receiver is awake and the current estimate is the active current
    `GDCPM_ASSERT_NOW(a_current_on, aclk, aresetn,
        m_valid && m_active_mode == gdcpm_pkg::MODE_ON,
        m_receiver_awake && m_current_estimate_ma == gdcpm_pkg::ACTIVE_MA)

    // Sleeping means standby and no current
    `GDCPM_ASSERT_NOW(a_sleep_idle, aclk, aresetn,
        m_valid && m_active_mode == gdcpm_pkg::MODE_INTER
        && m_duty_phase == gdcpm_pkg::PH_SLEEP,
        !m_receiver_awake && m_current_estimate_ma == gdcpm_pkg::IDLE_MA)

endmodule

bind gps_duty_cycle_power_manager_core gdcpm_checker u_gdcpm_checker (
    .aclk                  (aclk),
    .aresetn               (aresetn),
    .m_valid               (m_valid),
    .m_ready               (m_ready),
    .m_receiver_awake      (m_receiver_awake),
    .m_active_mode         (m_active_mode),
    .m_duty_phase          (m_duty_phase),
    .m_reverted_off        (m_reverted_off),
    .m_current_estimate_ma (m_current_estimate_ma)
);
